>>> rtl/assert_macros.svh
// assertion macros for the rtl of the life cellular automaton
// expects signals clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, ante, cons)

`define ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> rtl/lca_pkg.sv
// shared types and constants of the life cellular automaton
// no dependencies
package lca_pkg;

  localparam int GRID_ROWS = 24;
  localparam int GRID_COLS = 80;

  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int COL_AW = $clog2(GRID_COLS);
  localparam int ADV_CW = $clog2(GRID_ROWS + 1);

  localparam int MASK_W = 9;
  localparam int CNT_W  = 4;

  typedef logic [GRID_COLS-1:0] grid_row_t;
  typedef logic [ROW_AW-1:0]    row_idx_t;
  typedef logic [COL_AW-1:0]    col_idx_t;
  typedef logic [MASK_W-1:0]    rule_mask_t;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_NONE    = 2'd3
  } req_kind_t;

  localparam logic [1:0] CFG_BIRTH   = 2'd0;
  localparam logic [1:0] CFG_SURVIVE = 2'd1;

endpackage

>>> rtl/lca_row_next.sv
// next generation of one grid row from the old row and its two neighbor rows
// depends on lca_pkg
module lca_row_next (
  input  lca_pkg::grid_row_t  prev_row,
  input  lca_pkg::grid_row_t  cur_row,
  input  lca_pkg::grid_row_t  nxt_row,
  input  lca_pkg::rule_mask_t birth_mask,
  input  lca_pkg::rule_mask_t survive_mask,
  output lca_pkg::grid_row_t  new_row
);

  localparam int PW = lca_pkg::GRID_COLS + 2;

  logic [PW-1:0] prev_pad;
  logic [PW-1:0] cur_pad;
  logic [PW-1:0] nxt_pad;

  // dead cells beyond the left and right edges
  assign prev_pad = {1'b0, prev_row, 1'b0};
  assign cur_pad  = {1'b0, cur_row, 1'b0};
  assign nxt_pad  = {1'b0, nxt_row, 1'b0};

  for (genvar c = 0; c < lca_pkg::GRID_COLS; c++) begin : g_cell
    logic [lca_pkg::CNT_W-1:0] cnt;

    assign cnt = lca_pkg::CNT_W'(prev_pad[c]) + lca_pkg::CNT_W'(prev_pad[c+1])
               + lca_pkg::CNT_W'(prev_pad[c+2]) + lca_pkg::CNT_W'(cur_pad[c])
               + lca_pkg::CNT_W'(cur_pad[c+2]) + lca_pkg::CNT_W'(nxt_pad[c])
               + lca_pkg::CNT_W'(nxt_pad[c+1]) + lca_pkg::CNT_W'(nxt_pad[c+2]);

    assign new_row[c] = cur_pad[c+1] ? survive_mask[cnt] : birth_mask[cnt];
  end

endmodule

>>> rtl/life_cellular_automaton_unit.sv
// top level of the life cellular automaton: request handshake, row memory, sequencer
// depends on lca_pkg, lca_row_next and assert_macros.svh
//
// The grid lives in one row-wide memory (one entry per row, registered read), and one
// request is worked at a time. A cell write or read goes from acceptance to result in
// steps: the row read issued at acceptance, a read-modify-write or bit pick, and the
// result load. An advance reads each row once and writes it back once, through the
// single read and write port; a whole row of cells is ruled in parallel from three
// line buffers. Reset clears the grid at once through per-row valid bits, with no
// clearing pass. A new request is taken while the last result still waits on
// out_tready; a waiting result holds the next request only at its completion.
// Register writes are always ready.
`include "assert_macros.svh"

module life_cellular_automaton_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // row[4:0], col[11:5], cell_value[12], zero fill
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // cell_alive[0], zero fill
  output logic [1:0]  out_tuser,  // done_kind[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV_RD,
    ST_ADV_WR,
    ST_FIN
  } state_t;

  state_t                          state_r;
  lca_pkg::req_kind_t              kind_r;
  lca_pkg::row_idx_t               row_r;
  lca_pkg::col_idx_t               col_r;
  logic                            val_r;
  logic                            res_alive_r;
  logic [lca_pkg::ADV_CW-1:0]      adv_cnt_r;
  lca_pkg::grid_row_t              prev_r;
  lca_pkg::grid_row_t              cur_r;
  lca_pkg::rule_mask_t             birth_r;
  lca_pkg::rule_mask_t             survive_r;
  logic                            out_valid_r;
  logic                            out_alive_r;
  lca_pkg::req_kind_t              out_kind_r;
  logic [lca_pkg::GRID_ROWS-1:0]   row_valid_r;

  lca_pkg::grid_row_t              grid_mem [lca_pkg::GRID_ROWS];
  lca_pkg::grid_row_t              rdata_r;
  logic                            rvalid_r;

  lca_pkg::req_kind_t              in_kind;
  logic [4:0]                      in_row;
  logic [6:0]                      in_col;
  logic                            in_val;
  logic                            in_inside;
  logic                            in_acc;

  logic                            mem_re;
  lca_pkg::row_idx_t               mem_raddr;
  logic                            mem_we;
  lca_pkg::row_idx_t               mem_waddr;
  lca_pkg::grid_row_t              mem_wdata;

  lca_pkg::grid_row_t              base_row;
  lca_pkg::grid_row_t              incoming_row;
  lca_pkg::grid_row_t              new_row;
  logic                            adv_more;

  assign in_kind   = lca_pkg::req_kind_t'(in_tuser);
  assign in_row    = in_tdata[4:0];
  assign in_col    = in_tdata[11:5];
  assign in_val    = in_tdata[12];
  assign in_inside = (32'(in_row) < lca_pkg::GRID_ROWS) && (32'(in_col) < lca_pkg::GRID_COLS);
  assign in_acc    = in_tvalid && in_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_alive_r};
  assign out_tuser  = out_kind_r;
  assign cfg_ready  = 1'b1;

  assign adv_more     = (32'(adv_cnt_r) < lca_pkg::GRID_ROWS);
  assign base_row     = rvalid_r ? rdata_r : '0;
  assign incoming_row = (adv_more && rvalid_r) ? rdata_r : '0;

  lca_row_next u_row_next (
    .prev_row     (prev_r),
    .cur_row      (cur_r),
    .nxt_row      (incoming_row),
    .birth_mask   (birth_r),
    .survive_mask (survive_r),
    .new_row      (new_row)
  );

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = row_r;
    mem_we    = 1'b0;
    mem_waddr = row_r;
    mem_wdata = base_row;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_inside &&
            (in_kind == lca_pkg::REQ_WRITE || in_kind == lca_pkg::REQ_READ)) begin
          mem_re    = 1'b1;
          mem_raddr = lca_pkg::row_idx_t'(in_row);
        end
      end
      ST_CELL: begin
        if (kind_r == lca_pkg::REQ_WRITE) begin
          mem_we           = 1'b1;
          mem_wdata[col_r] = val_r;
        end
      end
      ST_ADV_RD: begin
        if (adv_more) begin
          mem_re    = 1'b1;
          mem_raddr = adv_cnt_r[lca_pkg::ROW_AW-1:0];
        end
      end
      ST_ADV_WR: begin
        if (adv_cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = lca_pkg::row_idx_t'(adv_cnt_r - 1'b1);
          mem_wdata = new_row;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= grid_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
      birth_r     <= lca_pkg::rule_mask_t'(8);
      survive_r   <= lca_pkg::rule_mask_t'(12);
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lca_pkg::CFG_BIRTH:   birth_r   <= cfg_data;
          lca_pkg::CFG_SURVIVE: survive_r <= cfg_data;
          default: begin
          end
        endcase
      end

      if (mem_re) begin
        rvalid_r <= row_valid_r[mem_raddr];
      end
      if (mem_we) begin
        row_valid_r[mem_waddr] <= 1'b1;
      end

      if (out_valid_r && out_tready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            kind_r      <= in_kind;
            row_r       <= lca_pkg::row_idx_t'(in_row);
            col_r       <= lca_pkg::col_idx_t'(in_col);
            val_r       <= in_val;
            res_alive_r <= 1'b0;
            adv_cnt_r   <= '0;
            prev_r      <= '0;
            cur_r       <= '0;
            unique case (in_kind)
              lca_pkg::REQ_WRITE,
              lca_pkg::REQ_READ:    state_r <= in_inside ? ST_CELL : ST_FIN;
              lca_pkg::REQ_ADVANCE: state_r <= ST_ADV_RD;
              lca_pkg::REQ_NONE:    state_r <= ST_FIN;
              default:              state_r <= ST_FIN;
            endcase
          end
        end
        ST_CELL: begin
          if (kind_r == lca_pkg::REQ_READ) begin
            res_alive_r <= base_row[col_r];
          end
          state_r <= ST_FIN;
        end
        ST_ADV_RD: begin
          state_r <= ST_ADV_WR;
        end
        ST_ADV_WR: begin
          prev_r <= cur_r;
          cur_r  <= incoming_row;
          if (adv_more) begin
            adv_cnt_r <= adv_cnt_r + 1'b1;
            state_r   <= ST_ADV_RD;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_alive_r <= res_alive_r;
            out_kind_r  <= kind_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_alive_only_on_read, out_valid_r && out_kind_r != lca_pkg::REQ_READ, !out_alive_r)
  `ASSERT_NXT(a_busy_after_accept, in_acc, state_r != ST_IDLE)
  `ASSERT_IMP(a_adv_count_bound, state_r == ST_ADV_WR, 32'(adv_cnt_r) <= lca_pkg::GRID_ROWS)
  `ASSERT_IMP(a_no_rw_overlap, mem_we && mem_re, mem_waddr != mem_raddr)

endmodule

>>> tb/life_cellular_automaton_unit_test.sv
// testbench for life_cellular_automaton_unit: directed cell writes, reads and advances,
// then windowed random patterns under several rule masks, checked by a grid predictor
// depends on lca_pkg and the rtl of life_cellular_automaton_unit
module life_cellular_automaton_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_COUNT = 7;
  localparam int ITEMS_PER_PHASE = 41;
  localparam int WIN = 6;
  localparam int DIRECTED_COUNT = 24;
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       alive;
  } reply_t;

  typedef struct packed {
    lca_pkg::req_kind_t kind;
    logic [4:0]         row;
    logic [6:0]         col;
    logic               value;
    logic               pinned;
    logic               alive;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{lca_pkg::REQ_READ,    5'd0,  7'd0,   1'b0, 1'b1, 1'b0},
    '{lca_pkg::REQ_READ,    5'd23, 7'd79,  1'b0, 1'b1, 1'b0},
    '{lca_pkg::REQ_WRITE,   5'd0,  7'd0,   1'b1, 1'b1, 1'b0},
    '{lca_pkg::REQ_WRITE,   5'd23, 7'd79,  1'b1, 1'b1, 1'b0},
    '{lca_pkg::REQ_READ,    5'd0,  7'd0,   1'b0, 1'b1, 1'b1},
    '{lca_pkg::REQ_READ,    5'd23, 7'd79,  1'b0, 1'b1, 1'b1},
    '{lca_pkg::REQ_WRITE,   5'd31, 7'd127, 1'b1, 1'b1, 1'b0},
    '{lca_pkg::REQ_READ,    5'd31, 7'd127, 1'b0, 1'b1, 1'b0},
    '{lca_pkg::REQ_WRITE,   5'd24, 7'd0,   1'b1, 1'b1, 1'b0},
    '{lca_pkg::REQ_READ,    5'd24, 7'd0,   1'b0, 1'b1, 1'b0},
    '{lca_pkg::REQ_WRITE,   5'd0,  7'd80,  1'b1, 1'b1, 1'b0},
    '{lca_pkg::REQ_READ,    5'd0,  7'd80,  1'b0, 1'b1, 1'b0},
    '{lca_pkg::REQ_NONE,    5'd17, 7'd64,  1'b1, 1'b1, 1'b0},
    '{lca_pkg::REQ_WRITE,   5'd0,  7'd1,   1'b1, 1'b1, 1'b0},
    '{lca_pkg::REQ_WRITE,   5'd0,  7'd2,   1'b1, 1'b1, 1'b0},
    '{lca_pkg::REQ_ADVANCE, 5'd0,  7'd0,   1'b0, 1'b1, 1'b0},
    '{lca_pkg::REQ_READ,    5'd0,  7'd1,   1'b0, 1'b0, 1'b0},
    '{lca_pkg::REQ_READ,    5'd1,  7'd1,   1'b0, 1'b0, 1'b0},
    '{lca_pkg::REQ_READ,    5'd0,  7'd0,   1'b0, 1'b0, 1'b0},
    '{lca_pkg::REQ_ADVANCE, 5'd0,  7'd0,   1'b0, 1'b1, 1'b0},
    '{lca_pkg::REQ_READ,    5'd23, 7'd79,  1'b0, 1'b0, 1'b0},
    '{lca_pkg::REQ_READ,    5'd22, 7'd78,  1'b0, 1'b0, 1'b0},
    '{lca_pkg::REQ_WRITE,   5'd23, 7'd79,  1'b0, 1'b1, 1'b0},
    '{lca_pkg::REQ_READ,    5'd23, 7'd79,  1'b0, 1'b1, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  bit                  life_grid [lca_pkg::GRID_ROWS][lca_pkg::GRID_COLS];
  lca_pkg::rule_mask_t birth_rule = 9'h008;
  lca_pkg::rule_mask_t survive_rule = 9'h00C;
  reply_t              due_replies [$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  bit                  steady_flow = 1'b0;
  int                  stall_left = 0;

  life_cellular_automaton_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void step_generation();
    bit nxt [lca_pkg::GRID_ROWS][lca_pkg::GRID_COLS];
    int n;
    int rr;
    int cc;
    for (int r = 0; r < lca_pkg::GRID_ROWS; r++) begin
      for (int c = 0; c < lca_pkg::GRID_COLS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < lca_pkg::GRID_ROWS &&
                cc >= 0 && cc < lca_pkg::GRID_COLS)
              n += int'(life_grid[5'(rr)][7'(cc)]);
          end
        end
        nxt[5'(r)][7'(c)] = life_grid[5'(r)][7'(c)] ? survive_rule[4'(n)] : birth_rule[4'(n)];
      end
    end
    life_grid = nxt;
  endfunction

  function automatic reply_t apply_request(lca_pkg::req_kind_t kind, logic [4:0] r,
                                           logic [6:0] c, logic v);
    reply_t rep;
    bit on_grid;
    on_grid = (r < lca_pkg::GRID_ROWS) && (c < lca_pkg::GRID_COLS);
    rep.alive = 1'b0;
    rep.kind = kind;
    case (kind)
      lca_pkg::REQ_WRITE: begin
        if (on_grid) life_grid[r][c] = v;
      end
      lca_pkg::REQ_ADVANCE: begin
        step_generation();
      end
      lca_pkg::REQ_READ: begin
        if (on_grid) rep.alive = life_grid[r][c];
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(99);
    if (steady_flow || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // entered and left just after a falling edge
  task automatic push_request(lca_pkg::req_kind_t kind, logic [4:0] r, logic [6:0] c, logic v,
                              bit pinned, logic pinned_alive);
    int gap;
    reply_t rep;
    gap = pick_pause();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, v, c, r};
    in_tuser <= kind;
    do @(posedge clk); while (!in_tready);
    rep = apply_request(kind, r, c, v);
    if (pinned) rep.alive = pinned_alive;
    due_replies.push_back(rep);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_replies.size() != 0) @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_register(logic [1:0] idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lca_pkg::CFG_BIRTH) birth_rule = data;
    else if (idx == lca_pkg::CFG_SURVIVE) survive_rule = data;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!steady_flow && $urandom_range(99) < 30)
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_replies.size() == 0) begin
        report_mismatch("done_kind of an unexpected result", int'(out_tuser), 0);
      end else begin
        want = due_replies.pop_front();
        if (out_tdata[0] !== want.alive)
          report_mismatch("cell_alive", int'(out_tdata[0]), int'(want.alive));
        if (out_tuser !== want.kind)
          report_mismatch("done_kind", int'(out_tuser), int'(want.kind));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    lca_pkg::rule_mask_t b;
    lca_pkg::rule_mask_t s;
    int roll;
    int base_r;
    int base_c;
    logic [4:0] r;
    logic [6:0] c;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i])
      push_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].row, DIRECTED_ROWS[i].col,
                   DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].alive);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      case (p)
        0: begin b = 9'h008; s = 9'h00C; end
        1: begin b = 9'h000; s = 9'h000; end
        2: begin b = 9'h1FF; s = 9'h1FF; end
        3: begin b = 9'h00C; s = 9'h00C; end
        4: begin b = 9'h1FF; s = 9'h000; end
        default: begin
          b = lca_pkg::rule_mask_t'($urandom_range(511));
          s = lca_pkg::rule_mask_t'($urandom_range(511));
        end
      endcase
      write_register(lca_pkg::CFG_BIRTH, b);
      write_register(lca_pkg::CFG_SURVIVE, s);
      write_register((p % 2 == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, 9'($urandom_range(511)));
      cfg_valid <= 1'b0;
      steady_flow = ($urandom_range(3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 20 == 0) begin
          roll = $urandom_range(2);
          base_r = (roll == 0) ? 0 : (roll == 1) ? lca_pkg::GRID_ROWS - WIN
                                                 : $urandom_range(lca_pkg::GRID_ROWS - WIN);
          roll = $urandom_range(2);
          base_c = (roll == 0) ? 0 : (roll == 1) ? lca_pkg::GRID_COLS - WIN
                                                 : $urandom_range(lca_pkg::GRID_COLS - WIN);
        end
        r = 5'(base_r + $urandom_range(WIN - 1));
        c = 7'(base_c + $urandom_range(WIN - 1));
        roll = $urandom_range(99);
        if (roll < 8)
          push_request(lca_pkg::req_kind_t'(2'($urandom_range(3))), 5'($urandom_range(31)),
                       7'($urandom_range(127)), 1'($urandom_range(1)), 1'b0, 1'b0);
        else if (roll < 40)
          push_request(lca_pkg::REQ_WRITE, r, c, $urandom_range(99) < 60, 1'b0, 1'b0);
        else if (roll < 52)
          push_request(lca_pkg::REQ_ADVANCE, 5'($urandom_range(31)), 7'($urandom_range(127)),
                       1'($urandom_range(1)), 1'b0, 1'b0);
        else
          push_request(lca_pkg::REQ_READ, r, c, 1'($urandom_range(1)), 1'b0, 1'b0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
